// ===== rtl/mfas_pkg.sv =====
// Package for the mixed fraction add/subtract core.
// Holds the transaction structs, the datapath width and the shared unit's request and response types.
// Used by mfas_alu and mixed_fraction_add_sub_core.
package mfas_pkg;

  // Width of the shared arithmetic datapath; products wrap at this width.
  localparam int unsigned DataWidth = 64;
  localparam int unsigned FieldWidth = 16;
  localparam int unsigned WholeWidth = 49;
  localparam int unsigned FracWidth = 32;
  localparam int unsigned OperandWidthDefault = 16;

  typedef enum logic [1:0] {
    OP_MUL = 2'd0,
    OP_DIV = 2'd1,
    OP_GCD = 2'd2
  } alu_op_e;

  typedef struct packed {
    logic                  cmd;
    logic [FieldWidth-1:0] whole_a;
    logic [FieldWidth-1:0] num_a;
    logic [FieldWidth-1:0] den_a;
    logic [FieldWidth-1:0] whole_b;
    logic [FieldWidth-1:0] num_b;
    logic [FieldWidth-1:0] den_b;
  } in_t;

  typedef struct packed {
    logic                  negative;
    logic [WholeWidth-1:0] whole_out;
    logic [FracWidth-1:0]  num_out;
    logic [FracWidth-1:0]  den_out;
    logic                  bad_input;
  } out_t;

  // Request to the shared unit: start pulse, operation and two operands.
  typedef struct packed {
    logic                 start;
    alu_op_e              op;
    logic [DataWidth-1:0] a;
    logic [DataWidth-1:0] b;
  } alu_req_t;

  // Response: done stays high until the next start; res is product, quotient or GCD.
  typedef struct packed {
    logic                 done;
    logic [DataWidth-1:0] res;
    logic [DataWidth-1:0] rem;
  } alu_rsp_t;

endpackage

// ===== rtl/mfas_alu.sv =====
// Shared iterative arithmetic unit: shift-add multiply, restoring divide, binary GCD.
// One step per cycle. Depends on mfas_pkg.
module mfas_alu
  import mfas_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  alu_req_t req_i,
  output alu_rsp_t rsp_o
);

  localparam int unsigned CntWidth = $clog2(DataWidth);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  alu_op_e              op_q, op_d;
  logic [DataWidth-1:0] a_q, a_d;
  logic [DataWidth-1:0] b_q, b_d;
  logic [DataWidth-1:0] acc_q, acc_d;
  logic [CntWidth-1:0]  cnt_q, cnt_d;
  logic [CntWidth-1:0]  k_q, k_d;
  logic [DataWidth:0]   part;
  logic [DataWidth:0]   part_diff;
  logic [DataWidth-1:0] ab_diff;
  logic [DataWidth-1:0] ba_diff;

  // Partial remainder of the divide and the two differences of the GCD step.
  assign part      = {acc_q, a_q[DataWidth-1]};
  assign part_diff = part - {1'b0, b_q};
  assign ab_diff   = a_q - b_q;
  assign ba_diff   = b_q - a_q;

  // One step of the selected operation.
  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    op_d   = op_q;
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    k_d    = k_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      op_d   = req_i.op;
      a_d    = req_i.a;
      b_d    = req_i.b;
      acc_d  = '0;
      cnt_d  = '0;
      k_d    = '0;
    end else if (busy_q) begin
      case (op_q)
        OP_MUL: begin
          if (b_q == '0) begin
            busy_d = 1'b0;
            done_d = 1'b1;
          end else begin
            if (b_q[0]) begin
              acc_d = acc_q + a_q;
            end
            a_d = a_q << 1;
            b_d = b_q >> 1;
          end
        end
        OP_DIV: begin
          if (!part_diff[DataWidth]) begin
            acc_d = part_diff[DataWidth-1:0];
            a_d   = {a_q[DataWidth-2:0], 1'b1};
          end else begin
            acc_d = part[DataWidth-1:0];
            a_d   = {a_q[DataWidth-2:0], 1'b0};
          end
          cnt_d = cnt_q + 1'b1;
          if (cnt_q == CntWidth'(DataWidth - 1)) begin
            busy_d = 1'b0;
            done_d = 1'b1;
          end
        end
        OP_GCD: begin
          if (a_q == '0) begin
            acc_d  = b_q << k_q;
            busy_d = 1'b0;
            done_d = 1'b1;
          end else if (b_q == '0) begin
            acc_d  = a_q << k_q;
            busy_d = 1'b0;
            done_d = 1'b1;
          end else if (!a_q[0] && !b_q[0]) begin
            a_d = a_q >> 1;
            b_d = b_q >> 1;
            k_d = k_q + 1'b1;
          end else if (!a_q[0]) begin
            a_d = a_q >> 1;
          end else if (!b_q[0]) begin
            b_d = b_q >> 1;
          end else if (a_q >= b_q) begin
            a_d = ab_diff >> 1;
          end else begin
            b_d = ba_diff >> 1;
          end
        end
        default: begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end
      endcase
    end
  end

  // Control flags are reset; operand registers are loaded by each start.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
    cnt_q <= cnt_d;
    k_q   <= k_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = (op_q == OP_DIV) ? a_q : acc_q;
  assign rsp_o.rem  = acc_q;

  a_busy_done_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(busy_q && done_q)) else $error("unit busy and done together");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |=> busy_q) else $error("start did not make the unit busy");
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(done_q) |-> $past(busy_q)) else $error("done raised without work");

endmodule

// ===== rtl/mixed_fraction_add_sub_core.sv =====
// Mixed fraction add/subtract core: adds or subtracts two mixed numbers and reduces the result.
// Uses mfas_pkg and one instance of mfas_alu.
//
// Use: the input channel (in_valid_i, in_stall_o, in_data_i) carries one transaction per
// calculation: cmd (0 add, 1 subtract b from a) and the two mixed numbers. The output channel
// (out_valid_o, out_stall_i, out_data_o) returns one transaction per input: sign, whole part,
// reduced remainder fraction and a flag for a zero denominator.
// A transaction is taken at an edge where valid is high and stall is low.
// One calculation at a time. With a zero denominator the result is
// valid in the cycle after acceptance. Otherwise the sequencer runs five shift-add multiplies
// (one multiplier bit per cycle), four or six restoring divides (64 steps each, six when a
// remainder is left) and up to two binary GCDs on the one shared unit. in_stall_o is high
// from acceptance until the result is taken. The result sits in an output register; while
// out_stall_i is high it holds and no new input is taken. Reset empties the output register
// and returns the sequencer to idle.
module mixed_fraction_add_sub_core
  import mfas_pkg::*;
#(
  parameter int unsigned OPERAND_WIDTH = OperandWidthDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  typedef enum logic [14:0] {
    S_IDLE = 15'b000000000000001,
    S_IA   = 15'b000000000000010,
    S_IB   = 15'b000000000000100,
    S_G    = 15'b000000000001000,
    S_L1   = 15'b000000000010000,
    S_L2   = 15'b000000000100000,
    S_FA   = 15'b000000001000000,
    S_SA   = 15'b000000010000000,
    S_FB   = 15'b000000100000000,
    S_SB   = 15'b000001000000000,
    S_W    = 15'b000010000000000,
    S_G2   = 15'b000100000000000,
    S_N    = 15'b001000000000000,
    S_D    = 15'b010000000000000,
    S_OUT  = 15'b100000000000000
  } state_e;

  state_e state_q, state_d;

  logic [OPERAND_WIDTH-1:0] wa, na, da, wb, nb, db;
  logic [OPERAND_WIDTH-1:0] na_q, na_d, da_q, da_d, wb_q, wb_d, nb_q, nb_d, db_q, db_d;
  logic                     sub_q, sub_d;
  logic [DataWidth-1:0]     ia_q, ia_d, ib_q, ib_d, l_q, l_d, sa_q, sa_d;
  logic [DataWidth-1:0]     rem_q, rem_d, g2_q, g2_d;
  logic                     neg_q, neg_d;
  logic                     bad_q, bad_d;
  logic [WholeWidth-1:0]    whole_q, whole_d;
  logic [FracWidth-1:0]     num_q, num_d, den_q, den_d;
  logic                     out_valid_q, out_valid_d;
  logic [DataWidth-1:0]     sum_ab, diff_ab, diff_ba;
  logic                     a_ge_b;
  alu_req_t                 req;
  alu_rsp_t                 rsp;

  // Operand fields reduced to the operand width.
  assign wa = OPERAND_WIDTH'(in_data_i.whole_a);
  assign na = OPERAND_WIDTH'(in_data_i.num_a);
  assign da = OPERAND_WIDTH'(in_data_i.den_a);
  assign wb = OPERAND_WIDTH'(in_data_i.whole_b);
  assign nb = OPERAND_WIDTH'(in_data_i.num_b);
  assign db = OPERAND_WIDTH'(in_data_i.den_b);

  // Scaled sum and differences, used once the second scaled term is ready.
  assign sum_ab  = sa_q + rsp.res;
  assign diff_ab = sa_q - rsp.res;
  assign diff_ba = rsp.res - sa_q;
  assign a_ge_b  = (sa_q >= rsp.res);

  // Sequencer: each working step waits for the shared unit, then issues the next operation or loads the result.
  always_comb begin
    state_d     = state_q;
    na_d        = na_q;
    da_d        = da_q;
    wb_d        = wb_q;
    nb_d        = nb_q;
    db_d        = db_q;
    sub_d       = sub_q;
    ia_d        = ia_q;
    ib_d        = ib_q;
    l_d         = l_q;
    sa_d        = sa_q;
    rem_d       = rem_q;
    g2_d        = g2_q;
    neg_d       = neg_q;
    bad_d       = bad_q;
    whole_d     = whole_q;
    num_d       = num_q;
    den_d       = den_q;
    out_valid_d = out_valid_q;
    req.start   = 1'b0;
    req.op      = OP_MUL;
    req.a       = '0;
    req.b       = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          na_d  = na;
          da_d  = da;
          wb_d  = wb;
          nb_d  = nb;
          db_d  = db;
          sub_d = in_data_i.cmd;
          if (da == '0 || db == '0) begin
            neg_d       = 1'b0;
            bad_d       = 1'b1;
            whole_d     = '0;
            num_d       = '0;
            den_d       = '0;
            out_valid_d = 1'b1;
            state_d     = S_OUT;
          end else begin
            bad_d     = 1'b0;
            neg_d     = 1'b0;
            req.start = 1'b1;
            req.op    = OP_MUL;
            req.a     = DataWidth'(wa);
            req.b     = DataWidth'(da);
            state_d   = S_IA;
          end
        end
      end
      S_IA: begin
        if (rsp.done) begin
          ia_d      = rsp.res + DataWidth'(na_q);
          req.start = 1'b1;
          req.op    = OP_MUL;
          req.a     = DataWidth'(wb_q);
          req.b     = DataWidth'(db_q);
          state_d   = S_IB;
        end
      end
      S_IB: begin
        if (rsp.done) begin
          ib_d      = rsp.res + DataWidth'(nb_q);
          req.start = 1'b1;
          req.op    = OP_GCD;
          req.a     = DataWidth'(da_q);
          req.b     = DataWidth'(db_q);
          state_d   = S_G;
        end
      end
      S_G: begin
        if (rsp.done) begin
          req.start = 1'b1;
          req.op    = OP_DIV;
          req.a     = DataWidth'(da_q);
          req.b     = rsp.res;
          state_d   = S_L1;
        end
      end
      S_L1: begin
        if (rsp.done) begin
          req.start = 1'b1;
          req.op    = OP_MUL;
          req.a     = rsp.res;
          req.b     = DataWidth'(db_q);
          state_d   = S_L2;
        end
      end
      S_L2: begin
        if (rsp.done) begin
          l_d       = rsp.res;
          req.start = 1'b1;
          req.op    = OP_DIV;
          req.a     = rsp.res;
          req.b     = DataWidth'(da_q);
          state_d   = S_FA;
        end
      end
      S_FA: begin
        if (rsp.done) begin
          req.start = 1'b1;
          req.op    = OP_MUL;
          req.a     = ia_q;
          req.b     = rsp.res;
          state_d   = S_SA;
        end
      end
      S_SA: begin
        if (rsp.done) begin
          sa_d      = rsp.res;
          req.start = 1'b1;
          req.op    = OP_DIV;
          req.a     = l_q;
          req.b     = DataWidth'(db_q);
          state_d   = S_FB;
        end
      end
      S_FB: begin
        if (rsp.done) begin
          req.start = 1'b1;
          req.op    = OP_MUL;
          req.a     = ib_q;
          req.b     = rsp.res;
          state_d   = S_SB;
        end
      end
      S_SB: begin
        if (rsp.done) begin
          req.start = 1'b1;
          req.op    = OP_DIV;
          req.b     = l_q;
          if (!sub_q) begin
            req.a = sum_ab;
          end else if (a_ge_b) begin
            req.a = diff_ab;
          end else begin
            req.a = diff_ba;
            neg_d = 1'b1;
          end
          state_d = S_W;
        end
      end
      S_W: begin
        if (rsp.done) begin
          whole_d = rsp.res[WholeWidth-1:0];
          rem_d   = rsp.rem;
          if (rsp.rem == '0) begin
            num_d       = '0;
            den_d       = FracWidth'(1);
            out_valid_d = 1'b1;
            state_d     = S_OUT;
          end else begin
            req.start = 1'b1;
            req.op    = OP_GCD;
            req.a     = rsp.rem;
            req.b     = l_q;
            state_d   = S_G2;
          end
        end
      end
      S_G2: begin
        if (rsp.done) begin
          g2_d      = rsp.res;
          req.start = 1'b1;
          req.op    = OP_DIV;
          req.a     = rem_q;
          req.b     = rsp.res;
          state_d   = S_N;
        end
      end
      S_N: begin
        if (rsp.done) begin
          num_d     = rsp.res[FracWidth-1:0];
          req.start = 1'b1;
          req.op    = OP_DIV;
          req.a     = l_q;
          req.b     = g2_q;
          state_d   = S_D;
        end
      end
      S_D: begin
        if (rsp.done) begin
          den_d       = rsp.res[FracWidth-1:0];
          out_valid_d = 1'b1;
          state_d     = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_stall_i) begin
          out_valid_d = 1'b0;
          state_d     = S_IDLE;
        end
      end
      default: begin
        out_valid_d = 1'b0;
        state_d     = S_IDLE;
      end
    endcase
  end

  mfas_alu u_alu (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .rsp_o (rsp)
  );

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working registers and the result register.
  always_ff @(posedge clk_i) begin
    na_q    <= na_d;
    da_q    <= da_d;
    wb_q    <= wb_d;
    nb_q    <= nb_d;
    db_q    <= db_d;
    sub_q   <= sub_d;
    ia_q    <= ia_d;
    ib_q    <= ib_d;
    l_q     <= l_d;
    sa_q    <= sa_d;
    rem_q   <= rem_d;
    g2_q    <= g2_d;
    neg_q   <= neg_d;
    bad_q   <= bad_d;
    whole_q <= whole_d;
    num_q   <= num_d;
    den_q   <= den_d;
  end

  assign in_stall_o            = (state_q != S_IDLE);
  assign out_valid_o           = out_valid_q;
  assign out_data_o.negative   = neg_q;
  assign out_data_o.whole_out  = whole_q;
  assign out_data_o.num_out    = num_q;
  assign out_data_o.den_out    = den_q;
  assign out_data_o.bad_input  = bad_q;

  a_out_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input open while a result waits");
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.bad_input) |-> (out_data_o.den_out == '0 &&
    out_data_o.num_out == '0 && !out_data_o.negative)) else $error("error result not cleared");
  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.bad_input) |-> (out_data_o.den_out != '0))
    else $error("zero denominator on a valid result");

endmodule
